### rtl/core/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("smc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("smc assertion failed");

`endif

### rtl/core/smc_pkg.sv
package smc_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int NUM_WAYS    = 4;
	localparam int ENTRY_DEPTH = 4;

	localparam int NUM_SETS = (NUM_ENTRIES / NUM_WAYS) == 0 ? 1 : NUM_ENTRIES / NUM_WAYS;
	localparam int IDX_W    = $clog2(NUM_ENTRIES);
	localparam int WIDX_W   = $clog2(NUM_ENTRIES + NUM_WAYS);
	localparam int SET_W    = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W    = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
	localparam int CNT_W    = $clog2(ENTRY_DEPTH + 1);
	localparam int HEAD_W   = ENTRY_DEPTH > 1 ? $clog2(ENTRY_DEPTH) : 1;
	localparam int QADDR_W  = $clog2(NUM_ENTRIES * ENTRY_DEPTH);
	localparam int VTX_W    = 32;
	localparam int FUNC_W   = 2;

	localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd2;

	typedef struct packed {
		logic [VTX_W-1:0]  tag;
		logic [CNT_W-1:0]  cnt;
		logic [HEAD_W-1:0] head;
	} ent_t;

	// (head + k) mod ENTRY_DEPTH; the sum stays below twice the depth
	function automatic logic [HEAD_W-1:0] slot_of(input logic [HEAD_W-1:0] head,
	                                              input logic [CNT_W-1:0] k);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(k);
		if (sum >= (CNT_W+1)'(ENTRY_DEPTH)) begin
			sum = sum - (CNT_W+1)'(ENTRY_DEPTH);
		end
		return HEAD_W'(sum);
	endfunction

	function automatic logic [QADDR_W-1:0] qaddr_of(input logic [IDX_W-1:0] idx,
	                                                input logic [HEAD_W-1:0] slot);
		return QADDR_W'(idx) * QADDR_W'(ENTRY_DEPTH) + QADDR_W'(slot);
	endfunction

endpackage

### rtl/core/smc_req_if.sv
interface smc_req_if;
	import smc_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [VTX_W-1:0]  dst_vertex;
	logic [VTX_W-1:0]  src_vertex;
	modport source (output valid, func, dst_vertex, src_vertex, input ready);
	modport sink (input valid, func, dst_vertex, src_vertex, output ready);
endinterface

### rtl/core/smc_rsp_if.sv
interface smc_rsp_if;
	import smc_pkg::*;
	logic             valid;
	logic             ready;
	logic             accepted;
	logic             found;
	logic [VTX_W-1:0] out_dst_vertex;
	logic [VTX_W-1:0] out_src_vertex;
	logic             last;
	modport source (output valid, accepted, found, out_dst_vertex, out_src_vertex, last,
		input ready);
	modport sink (input valid, accepted, found, out_dst_vertex, out_src_vertex, last,
		output ready);
endinterface

### rtl/core/set_assoc_message_coalescer_top.sv
// channel | direction | fields
// req     | in        | func, dst_vertex, src_vertex
// rsp     | out       | accepted, found, out_dst_vertex, out_src_vertex, last
//
// Send: one way checked per cycle of the entry memory read port.
// Tick: a read-modify-write sweep over the entry memory.
// Pop: a scan over up to NUM_ENTRIES entries, then a queue memory read and an output step per queued source.
// Reset clears valid bits, pop pointer and control; no clearing pass is needed.
// A stalled rsp holds its request; req is taken again once the item's last result is registered.
module set_assoc_message_coalescer_top (
	input logic        clk,
	input logic        arst_n,
	smc_req_if.sink    req,
	smc_rsp_if.source  rsp
);
	import smc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCHK  = 8'b0000_0010,
		S_TICK  = 8'b0000_0100,
		S_PSCAN = 8'b0000_1000,
		S_PENT  = 8'b0001_0000,
		S_QRD   = 8'b0010_0000,
		S_QOUT  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	ent_t             ent_mem [NUM_ENTRIES];
	logic [VTX_W-1:0] q_mem [NUM_ENTRIES*ENTRY_DEPTH];
	ent_t             ent_rd_q;
	logic [VTX_W-1:0] q_rd_q;

	logic [NUM_ENTRIES-1:0] valid_q;
	logic [WIDX_W-1:0]      base_q;
	logic [WAY_W-1:0]       w_q;
	logic [IDX_W-1:0]       empty_q;
	logic                   have_empty_q;
	logic [IDX_W-1:0]       tk_q;
	logic [IDX_W-1:0]       scan_q;
	logic [IDX_W-1:0]       n_q;
	logic [IDX_W-1:0]       ptr_q;
	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       pop_cnt_q;
	logic [HEAD_W-1:0]      pop_head_q;
	logic [VTX_W-1:0]       pop_tag_q;
	logic [VTX_W-1:0]       dst_q;
	logic [VTX_W-1:0]       src_q;
	logic                   res_acc_q;
	logic                   res_fnd_q;
	logic [VTX_W-1:0]       res_dst_q;
	logic                   rsp_valid_q;
	logic                   rsp_acc_q;
	logic                   rsp_fnd_q;
	logic [VTX_W-1:0]       rsp_dst_q;
	logic [VTX_W-1:0]       rsp_src_q;
	logic                   rsp_last_q;

	logic               req_acc;
	logic [SET_W-1:0]   set_idx;
	logic [WIDX_W-1:0]  req_base;
	logic [WIDX_W-1:0]  idx;
	logic [IDX_W-1:0]   way_in;
	logic               way_last;
	logic               ent_hit;
	logic               room;
	logic               empty_here;
	logic               out_free;
	logic               ent_re, ent_we, q_re, q_we;
	logic [IDX_W-1:0]   ent_raddr, ent_waddr;
	ent_t               ent_wdata;
	logic [QADDR_W-1:0] q_raddr, q_waddr;
	logic               v_set, v_clr;
	logic [IDX_W-1:0]   v_set_idx;
	logic               rsp_load;
	logic               ld_acc, ld_fnd, ld_last;
	logic [VTX_W-1:0]   ld_dst, ld_src;
	logic               sch_done, sch_ok;
	logic               pop_last;

	assign req.ready  = (state_q == S_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign set_idx    = SET_W'(req.dst_vertex % VTX_W'(NUM_SETS));
	assign req_base   = WIDX_W'(set_idx) * WIDX_W'(NUM_WAYS);
	assign idx        = base_q + WIDX_W'(w_q);
	assign way_in     = idx[IDX_W-1:0];
	assign way_last   = (w_q == WAY_W'(NUM_WAYS-1)) || (idx >= WIDX_W'(NUM_ENTRIES-1));
	assign ent_hit    = valid_q[way_in] && (ent_rd_q.tag == dst_q);
	assign room       = ent_rd_q.cnt < CNT_W'(ENTRY_DEPTH);
	assign empty_here = !valid_q[way_in];
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign pop_last   = (CNT_W'(k_q + 1'b1) == pop_cnt_q);

	always_comb begin
		state_d   = state_q;
		ent_re    = 1'b0;
		ent_raddr = '0;
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = '0;
		q_re      = 1'b0;
		q_raddr   = '0;
		q_we      = 1'b0;
		q_waddr   = '0;
		v_set     = 1'b0;
		v_set_idx = '0;
		v_clr     = 1'b0;
		rsp_load  = 1'b0;
		ld_acc    = 1'b0;
		ld_fnd    = 1'b0;
		ld_dst    = '0;
		ld_src    = '0;
		ld_last   = 1'b1;
		sch_done  = 1'b0;
		sch_ok    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					case (req.func)
						FUNC_SEND: begin
							ent_re    = 1'b1;
							ent_raddr = req_base[IDX_W-1:0];
							state_d   = S_SCHK;
						end
						FUNC_TICK: begin
							ent_re  = 1'b1;
							state_d = S_TICK;
						end
						FUNC_POP: state_d = S_PSCAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCHK: begin
				if (ent_hit && room) begin
					// append behind the current tail
					q_we      = 1'b1;
					q_waddr   = qaddr_of(way_in, slot_of(ent_rd_q.head, ent_rd_q.cnt));
					ent_we    = 1'b1;
					ent_waddr = way_in;
					ent_wdata = '{tag: ent_rd_q.tag, cnt: CNT_W'(ent_rd_q.cnt + 1'b1),
						head: ent_rd_q.head};
					sch_done  = 1'b1;
					sch_ok    = 1'b1;
				end else if (way_last) begin
					sch_done = 1'b1;
					if (empty_here || have_empty_q) begin
						// allocate the highest empty way seen
						v_set     = 1'b1;
						v_set_idx = empty_here ? way_in : empty_q;
						ent_we    = 1'b1;
						ent_waddr = v_set_idx;
						ent_wdata = '{tag: dst_q, cnt: CNT_W'(1), head: '0};
						q_we      = 1'b1;
						q_waddr   = qaddr_of(v_set_idx, '0);
						sch_ok    = 1'b1;
					end
				end else begin
					ent_re    = 1'b1;
					ent_raddr = IDX_W'(way_in + 1'b1);
				end
				if (sch_done) begin
					state_d = S_EMIT;
				end
			end
			S_TICK: begin
				if (valid_q[tk_q] && ent_rd_q.cnt > CNT_W'(1)) begin
					ent_we    = 1'b1;
					ent_waddr = tk_q;
					ent_wdata = '{tag: ent_rd_q.tag, cnt: CNT_W'(ent_rd_q.cnt - 1'b1),
						head: slot_of(ent_rd_q.head, CNT_W'(1))};
				end
				if (tk_q == IDX_W'(NUM_ENTRIES-1)) begin
					state_d = S_IDLE;
				end else begin
					ent_re    = 1'b1;
					ent_raddr = IDX_W'(tk_q + 1'b1);
				end
			end
			S_PSCAN: begin
				if (valid_q[scan_q]) begin
					ent_re    = 1'b1;
					ent_raddr = scan_q;
					state_d   = S_PENT;
				end else if (n_q == IDX_W'(NUM_ENTRIES-1)) begin
					state_d = S_EMIT;
				end
			end
			S_PENT: begin
				v_clr   = 1'b1;
				state_d = (ent_rd_q.cnt == '0) ? S_EMIT : S_QRD;
			end
			S_QRD: begin
				q_re    = 1'b1;
				q_raddr = qaddr_of(scan_q, slot_of(pop_head_q, k_q));
				state_d = S_QOUT;
			end
			S_QOUT: begin
				if (out_free) begin
					rsp_load = 1'b1;
					ld_fnd   = 1'b1;
					ld_dst   = pop_tag_q;
					ld_src   = q_rd_q;
					ld_last  = pop_last;
					state_d  = pop_last ? S_IDLE : S_QRD;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					rsp_load = 1'b1;
					ld_acc   = res_acc_q;
					ld_fnd   = res_fnd_q;
					ld_dst   = res_dst_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= src_q;
		end
		if (q_re) begin
			q_rd_q <= q_mem[q_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			base_q       <= '0;
			w_q          <= '0;
			empty_q      <= '0;
			have_empty_q <= 1'b0;
			tk_q         <= '0;
			scan_q       <= '0;
			n_q          <= '0;
			ptr_q        <= '0;
			k_q          <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (v_set) begin
				valid_q[v_set_idx] <= 1'b1;
			end
			if (v_clr) begin
				valid_q[scan_q] <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					base_q       <= req_base;
					w_q          <= '0;
					have_empty_q <= 1'b0;
					tk_q         <= '0;
					scan_q       <= ptr_q;
					n_q          <= '0;
					k_q          <= '0;
				end
				S_SCHK: begin
					w_q <= WAY_W'(w_q + 1'b1);
					if (empty_here) begin
						empty_q      <= way_in;
						have_empty_q <= 1'b1;
					end
				end
				S_TICK: tk_q <= IDX_W'(tk_q + 1'b1);
				S_PSCAN: begin
					if (!valid_q[scan_q]) begin
						scan_q <= (scan_q == IDX_W'(NUM_ENTRIES-1)) ? '0 : IDX_W'(scan_q + 1'b1);
						n_q    <= IDX_W'(n_q + 1'b1);
					end
				end
				S_PENT: begin
					ptr_q <= (scan_q == IDX_W'(NUM_ENTRIES-1)) ? '0 : IDX_W'(scan_q + 1'b1);
				end
				S_QOUT: begin
					if (rsp_load) begin
						k_q <= CNT_W'(k_q + 1'b1);
					end
				end
				default: ;
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			dst_q <= req.dst_vertex;
			src_q <= req.src_vertex;
		end
		if (state_q == S_SCHK && sch_done) begin
			res_acc_q <= sch_ok;
			res_fnd_q <= 1'b0;
			res_dst_q <= '0;
		end
		if (state_q == S_PSCAN) begin
			res_acc_q <= 1'b0;
			res_fnd_q <= 1'b0;
			res_dst_q <= '0;
		end
		if (state_q == S_PENT) begin
			pop_tag_q  <= ent_rd_q.tag;
			pop_cnt_q  <= ent_rd_q.cnt;
			pop_head_q <= ent_rd_q.head;
			res_acc_q  <= 1'b0;
			res_fnd_q  <= 1'b1;
			res_dst_q  <= ent_rd_q.tag;
		end
		if (rsp_load) begin
			rsp_acc_q  <= ld_acc;
			rsp_fnd_q  <= ld_fnd;
			rsp_dst_q  <= ld_dst;
			rsp_src_q  <= ld_src;
			rsp_last_q <= ld_last;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.accepted       = rsp_acc_q;
	assign rsp.found          = rsp_fnd_q;
	assign rsp.out_dst_vertex = rsp_dst_q;
	assign rsp.out_src_vertex = rsp_src_q;
	assign rsp.last           = rsp_last_q;

endmodule

### rtl/core/smc_checker.sv
`include "assert_macros.svh"

module smc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      accepted,
	input logic                      found,
	input logic [smc_pkg::VTX_W-1:0] out_dst_vertex,
	input logic [smc_pkg::VTX_W-1:0] out_src_vertex,
	input logic                      last
);
	import smc_pkg::*;

	// hold a stalled response
	`SMC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(out_src_vertex) && $stable(out_dst_vertex) && $stable(last))

	// a stored send never carries pop data
	`SMC_ASSERT_NOW(a_send_shape, clk, arst_n, rsp_valid && accepted,
		!found && last && out_dst_vertex == '0 && out_src_vertex == '0)

	// any response without found (an empty pop or a send that was not stored) is a single zero result
	`SMC_ASSERT_NOW(a_miss_shape, clk, arst_n, rsp_valid && !found,
		last && out_dst_vertex == '0 && out_src_vertex == '0)

	// no new request while a pop is still streaming
	`SMC_ASSERT_NOW(a_pop_busy, clk, arst_n, rsp_valid && !last, !req_ready && found)

endmodule

bind set_assoc_message_coalescer_top smc_checker u_smc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.accepted       (rsp.accepted),
	.found          (rsp.found),
	.out_dst_vertex (rsp.out_dst_vertex),
	.out_src_vertex (rsp.out_src_vertex),
	.last           (rsp.last)
);
